### rtl/pls_pkg.sv
// pls_pkg: shared types and constants for the positional list store.
// Used by pls_cell, pls_ctrl, positional_list_store_top and pls_checker.
package pls_pkg;

    localparam int CAPACITY   = 32;
    localparam int DATA_W     = 32;
    localparam int POS_W      = 6;
    localparam int COUNT_W    = 6;
    localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_SET    = 2'd2,
        ACT_GET    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // broadcast from control to every cell
    typedef struct packed {
        logic                apply;
        action_t             act;
        logic [CMP_W-1:0]    pos;
        logic [DATA_W-1:0]   value;
    } cell_cmd_t;

endpackage

### rtl/pls_cell.sv
// pls_cell: one list entry; loads, shifts from a neighbor or holds.
// Depends on pls_pkg.
module pls_cell
(
    input  logic                           clk,
    input  logic [pls_pkg::IDX_W-1:0]      idx,
    input  pls_pkg::cell_cmd_t             cmd,
    input  logic [pls_pkg::DATA_W-1:0]     left_data,
    input  logic [pls_pkg::DATA_W-1:0]     right_data,
    output logic [pls_pkg::DATA_W-1:0]     data,
    output logic [pls_pkg::DATA_W-1:0]     rd_data
);

    logic [pls_pkg::DATA_W-1:0] data_reg;
    logic [pls_pkg::DATA_W-1:0] data_next;
    logic [pls_pkg::CMP_W-1:0]  idx_ext;
    logic                       hit;
    logic                       above;

    assign idx_ext = pls_pkg::CMP_W'(idx);
    assign hit     = (idx_ext == cmd.pos);
    assign above   = (idx_ext > cmd.pos);

    always_comb
    begin
        data_next = data_reg;
        if (cmd.apply)
        begin
            case (cmd.act)
                pls_pkg::ACT_INSERT:
                begin
                    if (hit)
                        data_next = cmd.value;
                    else if (above)
                        data_next = left_data;
                end
                pls_pkg::ACT_REMOVE:
                begin
                    if (hit || above)
                        data_next = right_data;
                end
                pls_pkg::ACT_SET:
                begin
                    if (hit)
                        data_next = cmd.value;
                end
                default:
                begin
                    data_next = data_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    assign rd_data = hit ? data_reg : '0;

endmodule

### rtl/pls_ctrl.sv
// pls_ctrl: fill count, range and full checks, cell command, result register.
// Depends on pls_pkg.
module pls_ctrl
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  logic [1:0]                     action,
    input  logic [pls_pkg::POS_W-1:0]      position,
    input  logic [pls_pkg::DATA_W-1:0]     value,
    input  logic [pls_pkg::DATA_W-1:0]     rd_bus,
    output pls_pkg::cell_cmd_t             cmd,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output logic [pls_pkg::DATA_W-1:0]     read_value,
    output logic [pls_pkg::COUNT_W-1:0]    count,
    output logic                           is_empty,
    output logic [1:0]                     status
);

    logic [pls_pkg::CNT_W-1:0]   fill_reg;
    logic [pls_pkg::CNT_W-1:0]   fill_next;
    logic                        rsp_valid_reg;
    logic                        rsp_valid_next;
    logic [pls_pkg::DATA_W-1:0]  read_value_reg;
    logic [pls_pkg::COUNT_W-1:0] count_reg;
    logic                        is_empty_reg;
    pls_pkg::status_t            status_reg;

    logic                        accept;
    pls_pkg::action_t            act;
    pls_pkg::status_t            st;
    logic [pls_pkg::CMP_W-1:0]   pos_ext;
    logic [pls_pkg::CMP_W-1:0]   fill_ext;
    logic [pls_pkg::CMP_W-1:0]   fill_next_ext;
    logic [pls_pkg::DATA_W-1:0]  rd_sel;

    assign req_stall = rsp_valid_reg & rsp_stall;
    assign accept    = req_valid & ~req_stall;
    assign act       = pls_pkg::action_t'(action);
    assign pos_ext   = pls_pkg::CMP_W'(position);
    assign fill_ext  = pls_pkg::CMP_W'(fill_reg);

    always_comb
    begin
        st        = pls_pkg::ST_OK;
        fill_next = fill_reg;
        rd_sel    = '0;
        case (act)
            pls_pkg::ACT_INSERT:
            begin
                if (pos_ext > fill_ext)
                    st = pls_pkg::ST_RANGE;
                else if (fill_ext >= pls_pkg::CMP_W'(pls_pkg::CAPACITY))
                    st = pls_pkg::ST_FULL;
                else
                    fill_next = fill_reg + pls_pkg::CNT_W'(1);
            end
            pls_pkg::ACT_REMOVE:
            begin
                if (pos_ext >= fill_ext)
                    st = pls_pkg::ST_RANGE;
                else
                    fill_next = fill_reg - pls_pkg::CNT_W'(1);
            end
            pls_pkg::ACT_SET:
            begin
                if (pos_ext >= fill_ext)
                    st = pls_pkg::ST_RANGE;
            end
            pls_pkg::ACT_GET:
            begin
                if (pos_ext >= fill_ext)
                    st = pls_pkg::ST_RANGE;
                else
                    rd_sel = rd_bus;
            end
            default:
            begin
                st = pls_pkg::ST_OK;
            end
        endcase
    end

    assign fill_next_ext = pls_pkg::CMP_W'(fill_next);

    assign cmd.apply = accept && (st == pls_pkg::ST_OK);
    assign cmd.act   = act;
    assign cmd.pos   = pos_ext;
    assign cmd.value = value;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (accept)
            rsp_valid_next = 1'b1;
        else if (!rsp_stall)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (accept)
                fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            read_value_reg <= rd_sel;
            count_reg      <= fill_next_ext[pls_pkg::COUNT_W-1:0];
            is_empty_reg   <= (fill_next == '0);
            status_reg     <= st;
        end
    end

    assign rsp_valid  = rsp_valid_reg;
    assign read_value = read_value_reg;
    assign count      = count_reg;
    assign is_empty   = is_empty_reg;
    assign status     = status_reg;

endmodule

### rtl/positional_list_store_top.sv
// positional_list_store_top: fixed-capacity ordered list built as a row of cells.
// Depends on pls_pkg, pls_cell and pls_ctrl.
//
// Usage:
//   Request channel: req_valid / req_stall with action, position, value.
//   Response channel: rsp_valid / rsp_stall with read_value, count,
//   is_empty, status. An item moves when valid is high and stall is low.
//   Each request gives exactly one response item in the cycle after it is
//   accepted; one request per cycle is sustained while responses drain.
//   Insert and remove shift the cells at and above the position together:
//   insert loads the value there and each cell above from its left
//   neighbor, remove from the right. Get reads through an OR tree over the cells.
//   The response register decouples the channels; req_stall is raised only
//   while a response waits and rsp_stall is high.
//   Reset clears the fill count and the response valid; entry contents are
//   not cleared and are only read below the fill count.
//   Status: ok, position out of range, or full on insert into a full list.
module positional_list_store_top
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  logic [1:0]                     action,
    input  logic [pls_pkg::POS_W-1:0]      position,
    input  logic [pls_pkg::DATA_W-1:0]     value,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output logic [pls_pkg::DATA_W-1:0]     read_value,
    output logic [pls_pkg::COUNT_W-1:0]    count,
    output logic                           is_empty,
    output logic [1:0]                     status
);

    pls_pkg::cell_cmd_t          cmd;
    logic [pls_pkg::DATA_W-1:0]  cell_data [pls_pkg::CAPACITY];
    logic [pls_pkg::DATA_W-1:0]  cell_rd   [pls_pkg::CAPACITY];
    logic [pls_pkg::DATA_W-1:0]  rd_bus;

    genvar i;
    generate
        for (i = 0; i < pls_pkg::CAPACITY; i++)
        begin : g_cell
            logic [pls_pkg::DATA_W-1:0] left_d;
            logic [pls_pkg::DATA_W-1:0] right_d;

            if (i == 0)
            begin : g_first
                assign left_d = '0;
            end
            else
            begin : g_left
                assign left_d = cell_data[i-1];
            end

            if (i == pls_pkg::CAPACITY - 1)
            begin : g_last
                assign right_d = '0;
            end
            else
            begin : g_right
                assign right_d = cell_data[i+1];
            end

            pls_cell u_cell
            (
                .clk        (clk),
                .idx        (pls_pkg::IDX_W'(i)),
                .cmd        (cmd),
                .left_data  (left_d),
                .right_data (right_d),
                .data       (cell_data[i]),
                .rd_data    (cell_rd[i])
            );
        end
    endgenerate

    always_comb
    begin
        rd_bus = '0;
        for (int k = 0; k < pls_pkg::CAPACITY; k++)
            rd_bus = rd_bus | cell_rd[k];
    end

    pls_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .action     (action),
        .position   (position),
        .value      (value),
        .rd_bus     (rd_bus),
        .cmd        (cmd),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .read_value (read_value),
        .count      (count),
        .is_empty   (is_empty),
        .status     (status)
    );

endmodule

### rtl/pls_checker.sv
// pls_checker: port-level checks for positional_list_store_top, bound to it.
// Depends on pls_pkg.
module pls_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    input  logic                           req_stall,
    input  logic                           rsp_valid,
    input  logic                           rsp_stall,
    input  logic [pls_pkg::DATA_W-1:0]     read_value,
    input  logic [pls_pkg::COUNT_W-1:0]    count,
    input  logic                           is_empty,
    input  logic [1:0]                     status
);

    localparam logic [pls_pkg::CNT_W-1:0] CAP_CNT = pls_pkg::CNT_W'(pls_pkg::CAPACITY);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> rsp_valid)
        else $error("response dropped while stalled");

    a_req_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> rsp_valid)
        else $error("accepted request gave no response");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (is_empty == (count == '0)))
        else $error("empty flag disagrees with count");

    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status == pls_pkg::ST_FULL) |->
            (count == CAP_CNT[pls_pkg::COUNT_W-1:0]))
        else $error("full status with list not full");

    a_read: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && read_value != '0) |-> (status == pls_pkg::ST_OK))
        else $error("read data on failed request");

endmodule

bind positional_list_store_top pls_checker u_pls_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .read_value (read_value),
    .count      (count),
    .is_empty   (is_empty),
    .status     (status)
);
